FILE: src/snm_pkg.sv
// ----------------------------------------------------------------------------
// Short name mangler package
// Shared types, constants and byte helpers for the 8.3 short name generator.
// ----------------------------------------------------------------------------
package snm_pkg;

  localparam int unsigned BaseChars = 8;
  localparam int unsigned ExtChars  = 3;

  localparam logic [15:0] HashSeed  = 16'hf00f;
  localparam logic [7:0]  ChDot     = 8'h2e;
  localparam logic [7:0]  ChTilde   = 8'h7e;
  localparam logic [7:0]  ChUscore  = 8'h5f;
  localparam logic [7:0]  ChLowA    = 8'h61;
  localparam logic [7:0]  ChLowZ    = 8'h7a;
  localparam logic [7:0]  ChUpA     = 8'h41;
  localparam logic [7:0]  ChZero    = 8'h30;
  localparam logic [7:0]  CaseDelta = 8'h20;
  localparam logic [7:0]  CountMax  = 8'hff;

  // One finished name, handed from the front end to the emitter.
  typedef struct packed {
    logic [BaseChars-1:0][7:0] base;
    logic [ExtChars-1:0][7:0]  ext;
    logic [1:0]                ext_cnt;
    logic [3:0]                base_cnt;   // stored base bytes that are emitted
    logic [3:0]                base_len;   // base section length, 8 when hashed
    logic [3:0]                out_cnt;    // total bytes of the short name
    logic                      dot_name;
    logic                      needs_hash;
    logic [14:0]               hash;
  } rec_t;

  function automatic logic [15:0] mix(input logic [15:0] h);
    mix = {h[12:0], 3'b000} ^ {5'b00000, h[15:5]};
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    if (en && c >= ChLowA && c <= ChLowZ) begin
      fold = c - CaseDelta;
    end else begin
      fold = c;
    end
  endfunction

  // Letters A to Z, then digits 0 to 5.
  function automatic logic [7:0] hash_letter(input logic [4:0] idx);
    if (idx < 5'd26) begin
      hash_letter = ChUpA + {3'b000, idx};
    end else begin
      hash_letter = ChZero + {3'b000, idx - 5'd26};
    end
  endfunction

endpackage

FILE: src/short_name_8_3_mangler.sv
// The record of a name is registered in the record queue as its final name
// byte is accepted; its bytes then follow one per cycle while pop is held.
// Throughput: one name byte per cycle unless full; names yield 1 to 12 items.
// Full rises while two finished names wait in the record queue; every input
// item then waits until the emitter has sent the last byte of the oldest one.
// Reset: no names pending, per-name state cleared, case folding on.
// ----------------------------------------------------------------------------
// Short name mangler top level
// Builds 8.3 short names from long names arriving one byte per item.
// ----------------------------------------------------------------------------
module short_name_8_3_mangler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] name_byte_i,
  input  logic       name_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] short_byte_o,
  output logic       short_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic          fold_q;
  logic          accept;
  logic          rec_push;
  logic          rec_pop;
  logic          q_empty;
  snm_pkg::rec_t rec_in;
  snm_pkg::rec_t rec_head;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign empty       = q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fold_q <= cfg_data_i;
    end
  end

  snm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .name_byte_i (name_byte_i),
    .name_end_i  (name_end_i),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  snm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rec_push),
    .wr_data_i (rec_in),
    .full_o    (full),
    .rd_en_i   (rec_pop),
    .rd_data_o (rec_head),
    .empty_o   (q_empty)
  );

  snm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fold_i       (fold_q),
    .rec_i        (rec_head),
    .rec_valid_i  (!q_empty),
    .rec_pop_o    (rec_pop),
    .pop          (pop),
    .short_byte_o (short_byte_o),
    .short_last_o (short_last_o)
  );

endmodule

FILE: src/snm_front.sv
// ----------------------------------------------------------------------------
// Short name mangler front end
// Takes name bytes, tracks length, dots, stored bytes and the hash, and
// classifies the finished name into a record for the emitter.
// ----------------------------------------------------------------------------
module snm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          name_byte_i,
  input  logic                name_end_i,
  output logic                rec_push_o,
  output snm_pkg::rec_t       rec_o
);

  logic [7:0]  count_q, count_d;
  logic [7:0]  last_q, last_d;
  logic [7:0]  first_q, first_d;
  logic        dot_seen_q, dot_seen_d;
  logic [15:0] hash_q, hash_d;
  logic [7:0]  prior_q, prior_d;
  logic [1:0]  ext_cnt_q, ext_cnt_d;
  logic [snm_pkg::BaseChars-1:0][7:0] base_q, base_d;
  logic [snm_pkg::ExtChars-1:0][7:0]  ext_q, ext_d;

  logic [15:0] hash_run;
  logic [15:0] hash_fin;
  logic        has_dot;
  logic        long_name;
  logic [3:0]  base_cnt;
  logic [3:0]  base_len;
  logic        needs_hash;
  logic        dot_name;
  logic        end_item;

  always_comb begin
    count_d    = count_q;
    last_d     = last_q;
    first_d    = first_q;
    dot_seen_d = dot_seen_q;
    prior_d    = prior_q;
    ext_cnt_d  = ext_cnt_q;
    base_d     = base_q;
    ext_d      = ext_q;

    if (count_q != 8'd0) begin
      hash_run = snm_pkg::mix(hash_q) ^ {8'h00, prior_q} ^ {name_byte_i, 8'h00};
    end else begin
      hash_run = hash_q;
    end

    if (count_q < 8'(snm_pkg::BaseChars)) begin
      base_d[count_q[2:0]] = name_byte_i;
    end
    if (name_byte_i == snm_pkg::ChDot) begin
      if (!dot_seen_q) begin
        first_d = count_q;
      end
      last_d     = count_q;
      dot_seen_d = 1'b1;
      ext_cnt_d  = 2'd0;
    end else if (dot_seen_q && ext_cnt_q < 2'(snm_pkg::ExtChars)) begin
      ext_d[ext_cnt_q] = name_byte_i;
      ext_cnt_d        = ext_cnt_q + 2'd1;
    end
    prior_d = name_byte_i;
    if (count_q != snm_pkg::CountMax) begin
      count_d = count_q + 8'd1;
    end
    hash_fin = snm_pkg::mix(hash_run) ^ {8'h00, name_byte_i};

    // Classification of the name as it stands after this byte.
    has_dot = dot_seen_d && (last_d != 8'd0);
    if (has_dot) begin
      base_cnt = (last_d < 8'd8) ? last_d[3:0] : 4'd8;
    end else begin
      base_cnt = (count_d < 8'd8) ? count_d[3:0] : 4'd8;
    end
    long_name = (count_d > 8'd12)
              || (has_dot && (last_d > 8'd8 || (count_d - last_d) > 8'd4))
              || (!has_dot && count_d > 8'd8);
    // A dot among the emitted base bytes turns into an underscore; the first
    // dot is the earliest one, so comparing its place is enough.
    needs_hash = long_name || (dot_seen_d && first_d < {4'd0, base_cnt});
    base_len   = needs_hash ? 4'd8 : base_cnt;
    dot_name   = (base_d[0] == snm_pkg::ChDot)
              && (count_d == 8'd1 || (count_d == 8'd2 && base_d[1] == snm_pkg::ChDot));

    rec_o.base       = base_d;
    rec_o.ext        = ext_d;
    rec_o.ext_cnt    = ext_cnt_d;
    rec_o.base_cnt   = base_cnt;
    rec_o.base_len   = base_len;
    rec_o.dot_name   = dot_name;
    rec_o.needs_hash = needs_hash;
    rec_o.hash       = hash_fin[14:0];
    if (dot_name) begin
      rec_o.out_cnt = count_d[3:0];
    end else if (has_dot) begin
      rec_o.out_cnt = base_len + 4'd1 + {2'b00, ext_cnt_d};
    end else begin
      rec_o.out_cnt = base_len;
    end

    end_item   = accept_i && name_end_i;
    rec_push_o = end_item;

    if (end_item) begin
      count_d    = 8'd0;
      last_d     = 8'd0;
      first_d    = 8'd0;
      dot_seen_d = 1'b0;
      prior_d    = 8'd0;
      ext_cnt_d  = 2'd0;
      hash_d     = snm_pkg::HashSeed;
    end else begin
      hash_d = hash_run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= 8'd0;
      last_q     <= 8'd0;
      first_q    <= 8'd0;
      dot_seen_q <= 1'b0;
      hash_q     <= snm_pkg::HashSeed;
      prior_q    <= 8'd0;
      ext_cnt_q  <= 2'd0;
    end else if (accept_i) begin
      count_q    <= count_d;
      last_q     <= last_d;
      first_q    <= first_d;
      dot_seen_q <= dot_seen_d;
      hash_q     <= hash_d;
      prior_q    <= prior_d;
      ext_cnt_q  <= ext_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      base_q <= base_d;
      ext_q  <= ext_d;
    end
  end

  // Between names the hash must sit at its seed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 8'd0 |-> hash_q == snm_pkg::HashSeed)
    else $error("front: hash not at seed at the start of a name");

  // No extension bytes can be gathered before a dot has been seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dot_seen_q |-> ext_cnt_q == 2'd0)
    else $error("front: extension bytes without a dot");

endmodule

FILE: src/snm_queue.sv
// ----------------------------------------------------------------------------
// Short name mangler record queue
// Two-entry queue of finished name records between front end and emitter.
// ----------------------------------------------------------------------------
module snm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  snm_pkg::rec_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output snm_pkg::rec_t rd_data_o,
  output logic          empty_o
);

  snm_pkg::rec_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr_en_i, rd_en_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue: count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("queue: read from an empty queue");

endmodule

FILE: src/snm_back.sv
// ----------------------------------------------------------------------------
// Short name mangler emitter
// Walks the record at the queue head and produces one short name byte per
// accepted result item.
// ----------------------------------------------------------------------------
module snm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fold_i,
  input  snm_pkg::rec_t rec_i,
  input  logic          rec_valid_i,
  output logic          rec_pop_o,
  input  logic          pop,
  output logic [7:0]    short_byte_o,
  output logic          short_last_o
);

  logic [3:0] idx_q, idx_d;
  logic [3:0] ext_off;
  logic [7:0] stored;
  logic       take;

  always_comb begin
    ext_off = idx_q - rec_i.base_len - 4'd1;
    stored  = rec_i.base[idx_q[2:0]];

    if (rec_i.dot_name) begin
      short_byte_o = snm_pkg::ChDot;
    end else if (idx_q < rec_i.base_len) begin
      if (rec_i.needs_hash && idx_q >= 4'd4) begin
        unique case (idx_q[1:0])
          2'd0:    short_byte_o = snm_pkg::ChTilde;
          2'd1:    short_byte_o = snm_pkg::hash_letter(rec_i.hash[14:10]);
          2'd2:    short_byte_o = snm_pkg::hash_letter(rec_i.hash[9:5]);
          default: short_byte_o = snm_pkg::hash_letter(rec_i.hash[4:0]);
        endcase
      end else if (idx_q < rec_i.base_cnt) begin
        short_byte_o = (stored == snm_pkg::ChDot) ? snm_pkg::ChUscore
                                                  : snm_pkg::fold(stored, fold_i);
      end else begin
        short_byte_o = snm_pkg::ChTilde;
      end
    end else if (idx_q == rec_i.base_len) begin
      short_byte_o = snm_pkg::ChDot;
    end else begin
      short_byte_o = snm_pkg::fold(rec_i.ext[ext_off[1:0]], fold_i);
    end

    short_last_o = (idx_q == rec_i.out_cnt - 4'd1);
    take         = pop && rec_valid_i;
    rec_pop_o    = take && short_last_o;

    if (rec_pop_o) begin
      idx_d = 4'd0;
    end else if (take) begin
      idx_d = idx_q + 4'd1;
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i |-> (idx_q < rec_i.out_cnt && rec_i.out_cnt <= 4'd12))
    else $error("back: byte index outside the short name");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rec_valid_i |-> idx_q == 4'd0)
    else $error("back: index left over with no record waiting");

endmodule

FILE: sim/short_name_8_3_mangler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short name mangler testbench
// Feeds long names one byte per item and checks every emitted short name
// byte against a behavioural predictor, under random idling on both sides.
// ----------------------------------------------------------------------------
module short_name_8_3_mangler_tb;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned PhaseItems   = 40;
  localparam logic [8*32-1:0] HashAlphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ012345";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } short_char_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       push         = 1'b0;
  logic [7:0] name_byte_i  = 8'h00;
  logic       name_end_i   = 1'b0;
  logic       pop          = 1'b0;
  logic       cfg_valid_i  = 1'b0;
  logic       cfg_data_i   = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] short_byte_o;
  logic       short_last_o;
  logic       cfg_ready_o;

  // Predictor copy of the per-name state and the fold register.
  logic [7:0]  nm_base [snm_pkg::BaseChars];
  logic [7:0]  nm_ext [snm_pkg::ExtChars];
  logic [7:0]  nm_len;
  logic [7:0]  nm_last_dot;
  logic        nm_dot_seen;
  logic [15:0] nm_hash;
  logic [7:0]  nm_prior;
  int unsigned nm_ext_cnt;
  logic        fold_en = 1'b1;

  short_char_t short_name_q [$];
  logic [7:0]  long_name_q [$];
  short_char_t want;

  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned sent_items    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_left = 0;
  bit          offering      = 1'b0;

  short_name_8_3_mangler u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .name_byte_i  (name_byte_i),
    .name_end_i   (name_end_i),
    .empty        (empty),
    .pop          (pop),
    .short_byte_o (short_byte_o),
    .short_last_o (short_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: checks each accepted result, then decides whether to pop next.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (short_name_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %02h last %0b",
                 $time, short_byte_o, short_last_o);
        mismatches++;
      end else begin
        want = short_name_q.pop_front();
        if (short_byte_o !== want.ch) begin
          $display("%0t: short_byte expected %02h, got %02h", $time, want.ch, short_byte_o);
          mismatches++;
        end
        if (short_last_o !== want.last) begin
          $display("%0t: short_last expected %0b, got %0b", $time, want.last, short_last_o);
          mismatches++;
        end
      end
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] scramble(input logic [15:0] h);
    logic [15:0] up;
    up = h << 3;
    return up ^ (h >> 5);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (fold_en && c >= snm_pkg::ChLowA && c <= snm_pkg::ChLowZ) begin
      return c - snm_pkg::CaseDelta;
    end
    return c;
  endfunction

  task automatic clear_name_state();
    for (int i = 0; i < snm_pkg::BaseChars; i++) nm_base[i] = 8'h00;
    for (int i = 0; i < snm_pkg::ExtChars; i++) nm_ext[i] = 8'h00;
    nm_len      = 8'd0;
    nm_last_dot = 8'd0;
    nm_dot_seen = 1'b0;
    nm_hash     = snm_pkg::HashSeed;
    nm_prior    = 8'h00;
    nm_ext_cnt  = 0;
  endtask

  // Folds one accepted name byte into the state; on the final byte it
  // queues the whole short name that the block must emit.
  task automatic mangle_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  pos;
    logic [7:0]  outb [12];
    logic [4:0]  idx;
    int unsigned n;
    int unsigned len;
    bit          has_dot;
    bit          hashed;
    bit          stop;
    short_char_t sc;
    pos = nm_len;
    if (nm_len != 8'd0) begin
      nm_hash = scramble(nm_hash) ^ {8'h00, nm_prior} ^ {b, 8'h00};
    end
    if (pos < snm_pkg::BaseChars) nm_base[pos] = b;
    if (b == snm_pkg::ChDot) begin
      nm_last_dot = pos;
      nm_dot_seen = 1'b1;
      nm_ext_cnt  = 0;
    end else if (nm_dot_seen && nm_ext_cnt < snm_pkg::ExtChars) begin
      nm_ext[nm_ext_cnt] = b;
      nm_ext_cnt++;
    end
    nm_prior = b;
    if (nm_len != snm_pkg::CountMax) nm_len++;
    if (!fin) return;

    nm_hash = scramble(nm_hash) ^ {8'h00, b};
    len = nm_len;
    n = 0;
    if (nm_base[0] == snm_pkg::ChDot &&
        (len == 1 || (len == 2 && nm_base[1] == snm_pkg::ChDot))) begin
      for (int i = 0; i < len; i++) begin
        outb[n] = snm_pkg::ChDot;
        n++;
      end
    end else begin
      has_dot = nm_dot_seen && nm_last_dot != 8'd0;
      hashed = len > 12 || (has_dot && (nm_last_dot > 8 || len - nm_last_dot > 4)) ||
               (!has_dot && len > 8);
      stop = 1'b0;
      for (int i = 0; i < snm_pkg::BaseChars && !stop; i++) begin
        if (i >= len || (has_dot && i == nm_last_dot)) begin
          while (hashed && n < snm_pkg::BaseChars) begin
            outb[n] = snm_pkg::ChTilde;
            n++;
          end
          stop = 1'b1;
        end else if (nm_base[i] == snm_pkg::ChDot) begin
          // An inner dot in the base part cannot survive, so the name is hashed.
          outb[n] = snm_pkg::ChUscore;
          n++;
          hashed = 1'b1;
        end else begin
          outb[n] = upcase(nm_base[i]);
          n++;
        end
      end
      if (has_dot) begin
        outb[n] = snm_pkg::ChDot;
        n++;
        for (int i = 0; i < nm_ext_cnt; i++) begin
          outb[n] = upcase(nm_ext[i]);
          n++;
        end
      end
      if (hashed && n >= 8) begin
        outb[4] = snm_pkg::ChTilde;
        idx = nm_hash[14:10];
        outb[5] = HashAlphabet[8*(31-idx) +: 8];
        idx = nm_hash[9:5];
        outb[6] = HashAlphabet[8*(31-idx) +: 8];
        idx = nm_hash[4:0];
        outb[7] = HashAlphabet[8*(31-idx) +: 8];
      end
    end
    for (int i = 0; i < n; i++) begin
      sc.ch   = outb[i];
      sc.last = (i == n - 1);
      short_name_q.push_back(sc);
    end
    clear_name_state();
  endtask

  task automatic stop_offering();
    if (offering) begin
      push <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_name_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      stop_offering();
      @(posedge clk_i);
    end
    push        <= 1'b1;
    name_byte_i <= b;
    name_end_i  <= fin;
    offering = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    mangle_byte(b, fin);
    sent_items++;
  endtask

  task automatic send_long_name();
    for (int i = 0; i < long_name_q.size(); i++) begin
      send_name_byte(long_name_q[i], i == long_name_q.size() - 1);
    end
    long_name_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) long_name_q.push_back(s[i]);
    send_long_name();
  endtask

  function automatic logic [7:0] pick_name_byte(input bit allow_dot);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return snm_pkg::ChLowA + 8'($urandom_range(25));
    if (r < 55) return snm_pkg::ChUpA + 8'($urandom_range(25));
    if (r < 70) return allow_dot ? snm_pkg::ChDot : snm_pkg::ChTilde;
    if (r < 80) return snm_pkg::ChZero + 8'($urandom_range(9));
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic queue_random_bytes(input int unsigned count, input bit allow_dot);
    for (int i = 0; i < count; i++) long_name_q.push_back(pick_name_byte(allow_dot));
  endtask

  task automatic send_random_name();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) begin
      if (r[0]) begin
        send_text(".");
      end else begin
        send_text("..");
      end
    end else if (r < 56) begin
      // A plain base, one dot and a plain extension, lengths around the limits.
      queue_random_bytes($urandom_range(10, 1), 1'b0);
      long_name_q.push_back(snm_pkg::ChDot);
      queue_random_bytes($urandom_range(4), 1'b0);
      send_long_name();
    end else if (r < 92) begin
      queue_random_bytes($urandom_range(14, 1), 1'b1);
      send_long_name();
    end else begin
      queue_random_bytes($urandom_range(40, 15), 1'b1);
      send_long_name();
    end
  endtask

  task automatic wait_drained();
    stop_offering();
    while (short_name_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_fold(input logic v);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    fold_en = v;
  endtask

  task automatic test_dot_names();
    send_text(".");
    send_text("..");
    send_text("...");
  endtask

  task automatic test_leading_dot();
    send_text(".ab");
  endtask

  task automatic test_inner_dots();
    // Inner dots and an extension that is too long.
    send_text("a.b.cdef");
  endtask

  task automatic test_byte_extremes();
    send_text("\001\377z");
  endtask

  task automatic test_case_fold();
    write_fold(1'b0);
    send_text("aZ");
    write_fold(1'b1);
    send_text("aZ");
  endtask

  task automatic test_long_names();
    queue_random_bytes(9, 1'b0);
    send_long_name();
    send_text("abcdefgh.ijkl");
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 160;
    for (int i = 0; i < 16; i++) begin
      queue_random_bytes($urandom_range(3, 1), 1'b1);
      send_long_name();
    end
    wait_drained();
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input logic fold);
    int unsigned start;
    write_fold(fold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = sent_items;
    while (sent_items - start < PhaseItems) begin
      send_random_name();
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  initial begin
    clear_name_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dot_names();
    test_leading_dot();
    test_inner_dots();
    test_byte_extremes();
    test_case_fold();
    test_long_names();
    test_backpressure();
    test_random_phase(14, 88, 1'b0);
    test_random_phase(88, 14, 1'b1);
    test_random_phase(0, 0, 1'($urandom_range(1)));
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && short_name_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/snm_pkg.sv
src/snm_front.sv
src/snm_queue.sv
src/snm_back.sv
src/short_name_8_3_mangler.sv
sim/short_name_8_3_mangler_tb.sv
